// File: design/assert_macros.svh
// Assertion helpers shared by the design files.
// No dependencies; take in with `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge, off during reset.
`define SHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shs assertion failed");

// Next-cycle implication, checked on the rising edge, off during reset.
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shs assertion failed");

`endif

// File: design/shs_pkg.sv
// Constants, types and the coil pattern table of the half-step sequencer.
// No dependencies; used by the interfaces and all modules.
package shs_pkg;

  localparam int DEGREES_PER_UNIT    = 45;
  localparam int HALF_STEPS_PER_UNIT = 512;

  localparam int DEG_W   = 10;
  localparam int HS_W    = 14;
  localparam int TICK_W  = 16;
  localparam int PHASE_W = 3;
  localparam int COIL_W  = 4;

  localparam int QUOT_W  = $clog2(((1 << DEG_W) - 1) / DEGREES_PER_UNIT + 1);
  localparam int HSU_W   = $clog2(HALF_STEPS_PER_UNIT + 1);
  localparam int NFULL_W = QUOT_W + HSU_W;

  // degrees / DEGREES_PER_UNIT as multiply by rounded-up reciprocal;
  // the error stays below 1/1024 of a unit, under the smallest gap to the next unit.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + DEGREES_PER_UNIT - 1) / DEGREES_PER_UNIT;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = DEG_W + RECIP_W;

  localparam logic [HS_W-1:0]   HS_MAX           = {HS_W{1'b1}};
  localparam logic [TICK_W-1:0] STEP_TICKS_RESET = TICK_W'(1500);

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  typedef logic [COIL_W-1:0] coil_t;

  // Input beat after the angle is reduced to whole units.
  typedef struct packed {
    logic              cmd;
    logic [QUOT_W-1:0] units;
    logic              direction;
  } shs_item_t;

  localparam coil_t CW_PATTERN [8] = '{
    4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9
  };

  function automatic coil_t pattern_for(input logic dir, input logic [PHASE_W-1:0] phase);
    coil_t pat;
    if (dir) begin
      pat = CW_PATTERN[phase];
    end else begin
      pat = CW_PATTERN[~phase];
    end
    return pat;
  endfunction

endpackage

// File: design/shs_ifs.sv
// Valid/ready channel interfaces of the half-step sequencer.
// Depends on shs_pkg for field widths.
interface shs_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [shs_pkg::DEG_W-1:0]  degrees;
  logic                       direction;

  modport source (output valid, output cmd, output degrees, output direction, input ready);
  modport sink   (input valid, input cmd, input degrees, input direction, output ready);
endinterface

interface shs_out_if;
  logic                 valid;
  logic                 ready;
  shs_pkg::coil_t       coils;
  logic                 busy_res;
  logic                 done_res;
  logic                 rejected;

  modport source (output valid, output coils, output busy_res, output done_res,
                  output rejected, input ready);
  modport sink   (input valid, input coils, input busy_res, input done_res,
                  input rejected, output ready);
endinterface

// File: design/shs_in_stage.sv
// Input register of the sequencer: takes a beat and reduces degrees to whole units.
// Depends on shs_pkg and shs_in_if.
module shs_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  shs_in_if.sink             in_ch,
  input  logic               take,
  output logic               item_valid,
  output shs_pkg::shs_item_t item
);

  logic                        valid_r, valid_nxt;
  shs_pkg::shs_item_t          item_r, item_nxt;
  logic                        load;
  logic [shs_pkg::PROD_W-1:0]  prod;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  assign prod = shs_pkg::PROD_W'(in_ch.degrees) *
                shs_pkg::PROD_W'(shs_pkg::RECIP);

  always_comb begin
    valid_nxt = load || (valid_r && !take);
    item_nxt  = item_r;
    if (load) begin
      item_nxt.cmd       = in_ch.cmd;
      item_nxt.units     = prod[shs_pkg::RECIP_SHIFT +: shs_pkg::QUOT_W];
      item_nxt.direction = in_ch.direction;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: design/shs_core.sv
// Sequencer state, step logic and result register.
// Depends on shs_pkg and shs_out_if.
module shs_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [shs_pkg::TICK_W-1:0]  cfg_wdata,
  input  logic                        item_valid,
  input  shs_pkg::shs_item_t          item,
  output logic                        take,
  shs_out_if.source                   out_ch
);

  logic [shs_pkg::TICK_W-1:0]  step_ticks_r, step_ticks_nxt;
  logic [shs_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                        dir_r, dir_nxt;
  logic [shs_pkg::HS_W-1:0]    hs_left_r, hs_left_nxt;
  logic [shs_pkg::TICK_W-1:0]  hold_r, hold_nxt;
  logic                        running_r, running_nxt;
  shs_pkg::coil_t              coil_r, coil_nxt;

  logic                        out_valid_r, out_valid_nxt;
  shs_pkg::coil_t              out_coils_r, out_coils_nxt;
  logic                        out_busy_r, out_busy_nxt;
  logic                        out_done_r, out_done_nxt;
  logic                        out_rej_r, out_rej_nxt;

  logic [shs_pkg::NFULL_W-1:0] n_full;
  logic [shs_pkg::HS_W-1:0]    hs_start;
  logic [shs_pkg::TICK_W-1:0]  hold_load;
  logic [shs_pkg::HS_W-1:0]    hs_dec;
  logic                        done;
  logic                        rej;

  assign take = item_valid && (!out_valid_r || out_ch.ready);

  assign n_full   = shs_pkg::NFULL_W'(item.units) *
                    shs_pkg::NFULL_W'(shs_pkg::HALF_STEPS_PER_UNIT);
  assign hs_start = (n_full > shs_pkg::NFULL_W'(shs_pkg::HS_MAX)) ?
                    shs_pkg::HS_MAX : n_full[shs_pkg::HS_W-1:0];
  assign hold_load = (step_ticks_r == '0) ? shs_pkg::TICK_W'(1) : step_ticks_r;
  assign hs_dec    = (hs_left_r != '0) ? hs_left_r - shs_pkg::HS_W'(1) : hs_left_r;

  always_comb begin
    step_ticks_nxt = cfg_we ? cfg_wdata : step_ticks_r;
    phase_nxt      = phase_r;
    dir_nxt        = dir_r;
    hs_left_nxt    = hs_left_r;
    hold_nxt       = hold_r;
    running_nxt    = running_r;
    coil_nxt       = coil_r;
    done           = 1'b0;
    rej            = 1'b0;

    if (take) begin
      if (item.cmd == shs_pkg::CMD_MOVE) begin
        if (running_r) begin
          rej = 1'b1;
        end else begin
          dir_nxt     = item.direction;
          phase_nxt   = '0;
          hs_left_nxt = hs_start;
          if (hs_start == '0) begin
            done = 1'b1;
          end else begin
            running_nxt = 1'b1;
            coil_nxt    = shs_pkg::pattern_for(item.direction, '0);
            hold_nxt    = hold_load;
          end
        end
      end else if (running_r) begin
        if (hold_r > shs_pkg::TICK_W'(1)) begin
          hold_nxt = hold_r - shs_pkg::TICK_W'(1);
        end else begin
          hs_left_nxt = hs_dec;
          if (hs_dec == '0) begin
            // last half-step: stop and keep the coils where they are
            running_nxt = 1'b0;
            hold_nxt    = '0;
            done        = 1'b1;
          end else begin
            phase_nxt = phase_r + shs_pkg::PHASE_W'(1);
            coil_nxt  = shs_pkg::pattern_for(dir_r, phase_r + shs_pkg::PHASE_W'(1));
            hold_nxt  = hold_load;
          end
        end
      end
    end

    out_valid_nxt = take || (out_valid_r && !out_ch.ready);
    out_coils_nxt = take ? coil_nxt    : out_coils_r;
    out_busy_nxt  = take ? running_nxt : out_busy_r;
    out_done_nxt  = take ? done        : out_done_r;
    out_rej_nxt   = take ? rej         : out_rej_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r <= shs_pkg::STEP_TICKS_RESET;
      phase_r      <= '0;
      dir_r        <= 1'b0;
      hs_left_r    <= '0;
      hold_r       <= '0;
      running_r    <= 1'b0;
      coil_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      step_ticks_r <= step_ticks_nxt;
      phase_r      <= phase_nxt;
      dir_r        <= dir_nxt;
      hs_left_r    <= hs_left_nxt;
      hold_r       <= hold_nxt;
      running_r    <= running_nxt;
      coil_r       <= coil_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_coils_r <= out_coils_nxt;
    out_busy_r  <= out_busy_nxt;
    out_done_r  <= out_done_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.coils    = out_coils_r;
  assign out_ch.busy_res = out_busy_r;
  assign out_ch.done_res = out_done_r;
  assign out_ch.rejected = out_rej_r;

endmodule

// File: design/stepper_half_step_sequencer.sv
// Half-step sequencer for a four-coil stepper: input register, step logic, result register.
// An accepted input beat is registered in shs_in_stage, then its result in the result
// register of shs_core; while the result side stalls, the beat waits in the input register.
// Throughput: one beat per cycle unless the result side stalls; state updates on each take.
// Reset (rst_n low, synchronous): coils off, idle, step_ticks back to 1500.
// Depends on shs_pkg, shs_ifs, shs_in_stage, shs_core and assert_macros.svh.
`include "assert_macros.svh"

module stepper_half_step_sequencer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [shs_pkg::TICK_W-1:0] cfg_wdata,
  shs_in_if.sink                     in_ch,
  shs_out_if.source                  out_ch
);

  logic               item_valid;
  shs_pkg::shs_item_t item;
  logic               take;

  shs_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  shs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_ch     (out_ch)
  );

  `SHS_ASSERT_IMP(a_done_not_busy, clk, rst_n, out_ch.valid && out_ch.done_res, !out_ch.busy_res)
  `SHS_ASSERT_IMP(a_rej_only_busy, clk, rst_n, out_ch.valid && out_ch.rejected,
                  out_ch.busy_res && !out_ch.done_res)
  `SHS_ASSERT_IMP(a_stall_from_out, clk, rst_n, !in_ch.ready, out_ch.valid && !out_ch.ready)
  `SHS_ASSERT_NEXT(a_take_gives_out, clk, rst_n, take, out_ch.valid)

endmodule

// File: tb/tb_stepper_half_step_sequencer.sv
`timescale 1ns / 1ps
// Self-checking bench for stepper_half_step_sequencer: directed moves, then random traffic.
// Depends on shs_pkg, shs_ifs and the sequencer RTL.
module tb_stepper_half_step_sequencer;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD     = 120;
  localparam int unsigned RANDOM_ITEMS  = 170;

  typedef struct {
    shs_pkg::coil_t coils;
    logic           busy;
    logic           done;
    logic           rejected;
  } drive_result_t;

  // Track the motor state and the drive beats it should produce.
  class step_scoreboard;
    drive_result_t                pending[$];
    logic [shs_pkg::TICK_W-1:0]   step_ticks;
    logic [shs_pkg::PHASE_W-1:0]  phase_idx;
    logic                         dir_cw;
    logic [shs_pkg::HS_W-1:0]     steps_left;
    logic [shs_pkg::TICK_W-1:0]   hold_left;
    logic                         moving;
    shs_pkg::coil_t               coil_now;
    int unsigned                  errors;
    shs_pkg::coil_t               cw_seq[8];

    function new();
      step_ticks = shs_pkg::STEP_TICKS_RESET;
      phase_idx  = '0;
      dir_cw     = 1'b0;
      steps_left = '0;
      hold_left  = '0;
      moving     = 1'b0;
      coil_now   = '0;
      errors     = 0;
      cw_seq     = '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};
    endfunction

    function shs_pkg::coil_t coil_pattern(logic cw, logic [shs_pkg::PHASE_W-1:0] ph);
      return cw ? cw_seq[ph] : cw_seq[3'd7 - ph];
    endfunction

    function void note_input(logic cmd, logic [shs_pkg::DEG_W-1:0] deg, logic dir);
      drive_result_t              r;
      int unsigned                n;
      logic [shs_pkg::TICK_W-1:0] reload;
      r.done     = 1'b0;
      r.rejected = 1'b0;
      reload = (step_ticks == 0) ? shs_pkg::TICK_W'(1) : step_ticks;
      if (cmd == shs_pkg::CMD_MOVE) begin
        if (moving) begin
          r.rejected = 1'b1;
        end else begin
          n = (int'(deg) / shs_pkg::DEGREES_PER_UNIT) * shs_pkg::HALF_STEPS_PER_UNIT;
          if (n > int'(shs_pkg::HS_MAX)) n = shs_pkg::HS_MAX;
          dir_cw     = dir;
          phase_idx  = '0;
          steps_left = shs_pkg::HS_W'(n);
          if (n == 0) begin
            r.done = 1'b1;
          end else begin
            moving    = 1'b1;
            coil_now  = coil_pattern(dir_cw, '0);
            hold_left = reload;
          end
        end
      end else if (moving) begin
        if (hold_left > 1) begin
          hold_left--;
        end else begin
          if (steps_left > 0) steps_left--;
          if (steps_left == 0) begin
            moving    = 1'b0;
            hold_left = '0;
            r.done    = 1'b1;
          end else begin
            phase_idx = phase_idx + 1'b1;
            coil_now  = coil_pattern(dir_cw, phase_idx);
            hold_left = reload;
          end
        end
      end
      r.coils = coil_now;
      r.busy  = moving;
      pending.push_back(r);
    endfunction

    function void check_result(shs_pkg::coil_t coils, logic busy, logic done, logic rejected);
      drive_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected drive beat: coils=%0d busy=%0b done=%0b rejected=%0b",
               coils, busy, done, rejected);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (coils !== exp_r.coils) begin
        $error("coils: expected %0d, got %0d", exp_r.coils, coils);
        errors++;
      end
      if (busy !== exp_r.busy) begin
        $error("busy_res: expected %0b, got %0b", exp_r.busy, busy);
        errors++;
      end
      if (done !== exp_r.done) begin
        $error("done_res: expected %0b, got %0b", exp_r.done, done);
        errors++;
      end
      if (rejected !== exp_r.rejected) begin
        $error("rejected: expected %0b, got %0b", exp_r.rejected, rejected);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [shs_pkg::TICK_W-1:0] cfg_wdata = '0;
  logic                       rx_ready = 1'b1;
  logic                       calm = 1'b0;
  int unsigned                hold_req_seq = 0;
  int unsigned                hold_ack_seq = 0;
  int unsigned                rx_stall_left = 0;
  int unsigned                cycle_count = 0;
  step_scoreboard             sb;

  shs_in_if  in_ch();
  shs_out_if out_ch();

  assign out_ch.ready = rx_ready;

  stepper_half_step_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_stepper_half_step_sequencer failed");
      $finish;
    end
  end

  // Result side: check each beat, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.coils, out_ch.busy_res, out_ch.done_res, out_ch.rejected);
      end
      if (hold_req_seq != hold_ack_seq) begin
        hold_ack_seq  = hold_req_seq;
        rx_stall_left = LONG_HOLD;
      end else if (rx_stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
        rx_stall_left = $urandom_range(1, 8);
      end
      if (rx_stall_left > 0) begin
        rx_ready <= 1'b0;
        rx_stall_left--;
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  // Leaves valid high on return; the caller drops it before any wait.
  task automatic send_beat(input logic cmd, input logic [shs_pkg::DEG_W-1:0] deg,
                           input logic dir);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.degrees   <= deg;
    in_ch.direction <= dir;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(cmd, deg, dir);
  endtask

  task automatic send_tick();
    send_beat(shs_pkg::CMD_TICK, shs_pkg::DEG_W'($urandom_range(0, 1023)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic tick_to_idle();
    while (sb.moving) send_tick();
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_step_ticks(input logic [shs_pkg::TICK_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.step_ticks = value;
  endtask

  // When idle, start a move about half the time; while moving, mostly tick with a few stray moves.
  task automatic run_random(input int unsigned count);
    int unsigned               sel;
    logic [shs_pkg::DEG_W-1:0] deg;
    repeat (count) begin
      if ($urandom_range(0, sb.moving ? 19 : 1) == 0) begin
        sel = $urandom_range(0, 9);
        if (sel < 5) deg = shs_pkg::DEG_W'($urandom_range(0, 44));
        else if (sel < 9) deg = shs_pkg::DEG_W'($urandom_range(45, 89));
        else deg = shs_pkg::DEG_W'($urandom_range(0, 1023));
        send_beat(shs_pkg::CMD_MOVE, deg, 1'($urandom_range(0, 1)));
      end else begin
        send_tick();
      end
    end
  endtask

  initial begin
    logic [shs_pkg::TICK_W-1:0] settings[4];
    sb = new();
    in_ch.valid     = 1'b0;
    in_ch.cmd       = shs_pkg::CMD_TICK;
    in_ch.degrees   = '0;
    in_ch.direction = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle tick and short moves that finish at once.
    send_beat(shs_pkg::CMD_TICK, 10'd1023, 1'b1);
    send_beat(shs_pkg::CMD_MOVE, 10'd0, 1'b0);
    send_beat(shs_pkg::CMD_MOVE, 10'd44, 1'b1);

    // Zero setting holds each phase one tick: a full move, a move while busy,
    // and the result side held off long enough to back up.
    write_step_ticks(shs_pkg::TICK_W'(0));
    send_beat(shs_pkg::CMD_MOVE, 10'd45, 1'b1);
    send_tick();
    send_tick();
    send_tick();
    send_beat(shs_pkg::CMD_MOVE, 10'd90, 1'b0);
    hold_req_seq <= hold_req_seq + 1;
    tick_to_idle();
    send_beat(shs_pkg::CMD_TICK, 10'd0, 1'b0);

    settings = '{shs_pkg::TICK_W'(1), shs_pkg::TICK_W'(2),
                 shs_pkg::TICK_W'($urandom_range(3, 5)), shs_pkg::TICK_W'(65535)};
    foreach (settings[i]) begin
      write_step_ticks(settings[i]);
      if (i == 3) calm = 1'b1;
      run_random(RANDOM_ITEMS);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_stepper_half_step_sequencer passed");
    end else begin
      if (sb.pending.size() != 0) $error("%0d drive beats never arrived", sb.pending.size());
      $display("tb_stepper_half_step_sequencer failed");
    end
    $finish;
  end

endmodule
